// ===== sv/tsx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsx_pkg
// types and constants shared by the tcp timestamp option extractor
// ----------------------------------------------------------------------------
package tsx_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned TS_W     = 32;
   localparam int unsigned CNT_W    = 6;
   localparam int unsigned WORDS_W  = 4;
   localparam int unsigned GOT_W    = 3;

   localparam logic [CNT_W-1:0]   DOFF_IDX   = 6'd12;
   localparam logic [CNT_W-1:0]   OPT_START  = 6'd20;
   localparam logic [CNT_W-1:0]   CNT_MAX    = 6'd63;
   localparam logic [WORDS_W-1:0] BASE_WORDS = 4'd5;
   localparam logic [GOT_W-1:0]   TS_BYTES   = 3'd4;

   localparam logic [BYTE_W-1:0] KIND_EOL = 8'd0;
   localparam logic [BYTE_W-1:0] KIND_NOP = 8'd1;
   localparam logic [BYTE_W-1:0] KIND_TS  = 8'd8;
   localparam logic [BYTE_W-1:0] TS_LEN   = 8'd10;
   localparam logic [BYTE_W-1:0] MIN_LEN  = 8'd2;

   typedef enum logic [2:0] {
      PH_KIND = 3'd0,
      PH_LEN  = 3'd1,
      PH_SKIP = 3'd2,
      PH_TS   = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_NO_OPT = 2'd1,
      ST_ABSENT = 2'd2,
      ST_BAD    = 2'd3
   } status_type;

   typedef struct packed {
      logic [TS_W-1:0] ts_value;
      status_type      status;
   } res_type;

endpackage
`default_nettype wire

// ===== sv/tsx_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsx_walk
// parse state of the option walk, advanced by one header byte per step
// ----------------------------------------------------------------------------
module tsx_walk (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_en,
   input  wire logic [tsx_pkg::BYTE_W-1:0]  step_byte,
   input  wire logic                        step_last,
   output tsx_pkg::res_type                 step_res
);
   import tsx_pkg::*;

   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [WORDS_W-1:0] words_ff, words_in;
   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  skip_ff,  skip_in;
   logic [TS_W-1:0]    shift_ff, shift_in;
   logic [GOT_W-1:0]   got_ff,   got_in;
   status_type         wstat_ff, wstat_in;
   logic               is_ts_ff, is_ts_in;

   logic [WORDS_W-1:0] words_cur;
   logic [CNT_W-1:0]   hdr_len;
   logic [CNT_W:0]     cnt_next1;
   logic [BYTE_W:0]    opt_end;
   logic [BYTE_W-1:0]  skip_dec;
   logic [GOT_W-1:0]   got_inc;
   status_type         final_st;

   always_comb begin
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      shift_in = shift_ff;
      got_in   = got_ff;
      wstat_in = wstat_ff;
      is_ts_in = is_ts_ff;

      words_cur = (cnt_ff == DOFF_IDX) ? step_byte[7:4] : words_ff;
      words_in  = words_cur;
      hdr_len   = {words_cur, 2'b00};
      cnt_next1 = {1'b0, cnt_ff} + 7'd1;
      opt_end   = {3'b000, cnt_ff} - 9'd1 + {1'b0, step_byte};
      skip_dec  = (skip_ff != '0) ? skip_ff - 8'd1 : skip_ff;
      got_inc   = got_ff + 3'd1;

      if (phase_ff != PH_DONE && cnt_ff != CNT_MAX) begin
         if (cnt_ff == OPT_START - 6'd1 && words_cur <= BASE_WORDS) begin
            phase_in = PH_DONE;
            wstat_in = ST_NO_OPT;
         end else if (cnt_ff >= OPT_START && cnt_ff < hdr_len) begin
            case (phase_ff)
               PH_KIND: begin
                  if (step_byte == KIND_EOL) begin
                     phase_in = PH_DONE;
                     wstat_in = ST_ABSENT;
                  end else if (step_byte == KIND_NOP) begin
                     phase_in = PH_KIND;
                  end else if (cnt_next1 >= {1'b0, hdr_len}) begin
                     phase_in = PH_DONE;
                     wstat_in = ST_BAD;
                  end else begin
                     is_ts_in = (step_byte == KIND_TS);
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (step_byte < MIN_LEN) begin
                     phase_in = PH_DONE;
                     wstat_in = ST_BAD;
                  end else if (opt_end > {3'b000, hdr_len}) begin
                     phase_in = PH_DONE;
                     wstat_in = ST_BAD;
                  end else if (is_ts_ff && step_byte == TS_LEN) begin
                     phase_in = PH_TS;
                     shift_in = '0;
                     got_in   = '0;
                  end else if (step_byte == MIN_LEN) begin
                     phase_in = PH_KIND;
                  end else begin
                     skip_in  = step_byte - MIN_LEN;
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_dec == '0) begin
                     phase_in = PH_KIND;
                  end
               end
               PH_TS: begin
                  shift_in = {shift_ff[TS_W-BYTE_W-1:0], step_byte};
                  got_in   = got_inc;
                  if (got_inc >= TS_BYTES) begin
                     phase_in = PH_DONE;
                     wstat_in = ST_FOUND;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (phase_in != PH_DONE && cnt_next1 == {1'b0, hdr_len}) begin
               phase_in = PH_DONE;
               wstat_in = ST_ABSENT;
            end
         end
      end

      if (cnt_ff != CNT_MAX) begin
         cnt_in = cnt_next1[CNT_W-1:0];
      end

      final_st = (phase_in == PH_DONE) ? wstat_in : ST_BAD;
      step_res.status   = final_st;
      step_res.ts_value = (final_st == ST_FOUND) ? shift_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && step_last)) begin
         cnt_ff   <= '0;
         words_ff <= '0;
         phase_ff <= PH_KIND;
         skip_ff  <= '0;
         shift_ff <= '0;
         got_ff   <= '0;
         wstat_ff <= ST_ABSENT;
         is_ts_ff <= 1'b0;
      end else if (step_en) begin
         cnt_ff   <= cnt_in;
         words_ff <= words_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         shift_ff <= shift_in;
         got_ff   <= got_in;
         wstat_ff <= wstat_in;
         is_ts_ff <= is_ts_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tcp_timestamp_option_extract_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_timestamp_option_extract_unit
// walks tcp header options one byte a beat and reports the timestamp value
// ----------------------------------------------------------------------------
//  channel | dir | tdata               | tuser      | tlast
//  req_    | in  | [7:0] hdr_byte      | -          | last
//  rsp_    | out | [31:0] ts_value     | [1:0] status | -
//
//  one header byte per cycle unless a held result stalls a last beat; input register, walk logic, result register
//  the result register loads when the last byte advances out of the input register
//  a held result stalls only a last beat; other bytes keep flowing
//  synchronous reset clears the walk state and both valid flags
// ----------------------------------------------------------------------------
module tcp_timestamp_option_extract_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [7:0]                  req_tdata,  // hdr_byte
   input  wire logic                        req_tlast,
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   output      logic [31:0]                 rsp_tdata,  // ts_value
   output      logic [1:0]                  rsp_tuser   // status
);
   import tsx_pkg::*;

   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              out_vld_ff, out_vld_in;
   res_type           out_res_ff;
   res_type           step_res;
   logic              advance;

   assign advance    = in_vld_ff && (!in_last_ff || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   tsx_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (in_byte_ff),
      .step_last (in_last_ff),
      .step_res  (step_res)
   );

   always_comb begin
      out_vld_in = out_vld_ff;
      if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_res_ff.ts_value;
   assign rsp_tuser  = out_res_ff.status;

endmodule
`default_nettype wire

// ===== tb/ts_extract_check.sv =====
// ----------------------------------------------------------------------------
// ts_extract_check
// watches both channels of the timestamp option extractor, keeps its own
// model of the option walk and compares each result beat with the oldest
// predicted header verdict
// ----------------------------------------------------------------------------
module ts_extract_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               bad_count,
   output int               due_count,
   output int               checked_count,
   output int               found_count
);
   import tsx_pkg::*;

   logic [CNT_W-1:0]   pos_cnt;
   logic [WORDS_W-1:0] doff_words;
   phase_type          walk_phase;
   logic [BYTE_W-1:0]  skip_cnt;
   logic [BYTE_W-1:0]  opt_kind;
   logic [TS_W-1:0]    ts_acc;
   logic [GOT_W-1:0]   ts_got;
   status_type         verdict;
   res_type            due_results[$];
   int                 fails;
   int                 checked;
   int                 found;

   function automatic void restart_walk();
      pos_cnt    = '0;
      doff_words = '0;
      walk_phase = PH_KIND;
      skip_cnt   = '0;
      opt_kind   = '0;
      ts_acc     = '0;
      ts_got     = '0;
      verdict    = ST_ABSENT;
   endfunction

   function automatic void conclude(status_type st);
      walk_phase = PH_DONE;
      verdict    = st;
   endfunction

   function automatic void walk_option_byte(int unsigned b, logic [7:0] v, int unsigned hlen);
      case (walk_phase)
         PH_KIND: begin
            if (v == KIND_EOL) begin
               conclude(ST_ABSENT);
            end else if (v == KIND_NOP) begin
            end else if (b + 1 >= hlen) begin
               conclude(ST_BAD);
            end else begin
               opt_kind   = v;
               walk_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            if (v < MIN_LEN) begin
               conclude(ST_BAD);
            end else if ((b - 1) + v > hlen) begin
               conclude(ST_BAD);
            end else if (opt_kind == KIND_TS && v == TS_LEN) begin
               walk_phase = PH_TS;
               ts_acc     = '0;
               ts_got     = '0;
            end else if (v == MIN_LEN) begin
               walk_phase = PH_KIND;
            end else begin
               skip_cnt   = v - MIN_LEN;
               walk_phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (skip_cnt > 0) skip_cnt = skip_cnt - 8'd1;
            if (skip_cnt == 0) walk_phase = PH_KIND;
         end
         PH_TS: begin
            ts_acc = {ts_acc[TS_W-BYTE_W-1:0], v};
            ts_got = ts_got + 3'd1;
            if (ts_got >= TS_BYTES) conclude(ST_FOUND);
         end
         default: ;
      endcase
      // option area exhausted without a verdict
      if (walk_phase != PH_DONE && b + 1 == hlen) conclude(ST_ABSENT);
   endfunction

   function automatic void absorb_header_byte(logic [7:0] v, logic is_last);
      int unsigned b;
      int unsigned hlen;
      status_type  st;
      res_type     res;
      b = pos_cnt;
      if (pos_cnt == DOFF_IDX) doff_words = v[7:4];
      hlen = {doff_words, 2'b00};
      if (walk_phase != PH_DONE && pos_cnt < CNT_MAX) begin
         if (pos_cnt == OPT_START - 1 && doff_words <= BASE_WORDS) begin
            conclude(ST_NO_OPT);
         end else if (pos_cnt >= OPT_START && b < hlen) begin
            walk_option_byte(b, v, hlen);
         end
      end
      if (pos_cnt < CNT_MAX) pos_cnt = pos_cnt + 6'd1;
      if (is_last) begin
         st           = (walk_phase == PH_DONE) ? verdict : ST_BAD;
         res.status   = st;
         res.ts_value = (st == ST_FOUND) ? ts_acc : '0;
         due_results.push_back(res);
         restart_walk();
      end
   endfunction

   function automatic void note_fail(string what);
      if (fails < 10) $display("mismatch: %s", what);
      fails++;
   endfunction

   initial begin
      restart_walk();
      fails   = 0;
      checked = 0;
      found   = 0;
   end

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         restart_walk();
         due_results.delete();
      end else begin
         if (req_tvalid && req_tready) absorb_header_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               note_fail($sformatf("result ts_value %h status %0d with none pending",
                                   rsp_tdata, rsp_tuser));
            end else begin
               want = due_results.pop_front();
               checked++;
               if (want.status == ST_FOUND) found++;
               if (rsp_tdata !== want.ts_value)
                  note_fail($sformatf("ts_value expected %h got %h",
                                      want.ts_value, rsp_tdata));
               if (rsp_tuser !== want.status)
                  note_fail($sformatf("status expected %s got %0d",
                                      want.status.name(), rsp_tuser));
            end
         end
      end
      bad_count     <= fails;
      due_count     <= due_results.size();
      checked_count <= checked;
      found_count   <= found;
   end

endmodule

// ===== tb/tcp_timestamp_option_extract_unit_test.sv =====
// ----------------------------------------------------------------------------
// tcp_timestamp_option_extract_unit_test
// feeds tcp headers byte by byte into the timestamp option extractor: a
// directed set for offsets, option kinds and broken headers, then random
// headers with random gaps and result stalls, one long result hold-off and
// drain pauses; checking is done by ts_extract_check
// ----------------------------------------------------------------------------
module tcp_timestamp_option_extract_unit_test;
   import tsx_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // hdr_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // ts_value
   logic [1:0]  rsp_tuser;   // status

   int          bad_count;
   int          due_count;
   int          checked_count;
   int          found_count;

   logic [7:0]  frame[$];
   bit          quiet_sender = 1'b0;
   int          hold_cycles = 0;
   int          bytes_sent = 0;
   int          frames_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tcp_timestamp_option_extract_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ts_extract_check i_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .bad_count     (bad_count),
      .due_count     (due_count),
      .checked_count (checked_count),
      .found_count   (found_count)
   );

   task automatic send_beat(input logic [7:0] value, input logic is_last);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_beat(frame[i], i == frame.size() - 1);
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
   endtask

   function automatic void fill_to(int n);
      while (frame.size() < n) frame.push_back(8'($urandom_range(0, 255)));
   endfunction

   // fixed header part with the data offset in the upper nibble of byte 12
   function automatic void start_frame(int words);
      frame.delete();
      fill_to(12);
      frame.push_back({words[3:0], 4'($urandom_range(0, 15))});
      fill_to(20);
   endfunction

   function automatic void put_option_area(int words);
      int hlen;
      int room;
      int r;
      int len;
      hlen = words * 4;
      while (frame.size() < hlen) begin
         room = hlen - frame.size();
         r    = $urandom_range(0, 99);
         if (r < 10) begin
            frame.push_back(KIND_NOP);
         end else if (r < 15) begin
            frame.push_back(KIND_EOL);
            fill_to(hlen);
         end else if (r < 45 && room >= 10) begin
            frame.push_back(KIND_TS);
            frame.push_back(TS_LEN);
            repeat (8) frame.push_back(8'($urandom_range(0, 255)));
         end else if (r < 80 && room >= 2) begin
            len = $urandom_range(2, room < 12 ? room : 12);
            frame.push_back(8'($urandom_range(2, 255)));
            frame.push_back(8'(len));
            repeat (len - 2) frame.push_back(8'($urandom_range(0, 255)));
         end else if (r < 90) begin
            frame.push_back(8'($urandom_range(0, 255)));
         end else begin
            // broken option: short or oversized length
            frame.push_back(8'($urandom_range(2, 255)));
            frame.push_back((r < 95) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255)));
         end
      end
   endfunction

   function automatic void build_random_frame();
      int words;
      int cut;
      words = ($urandom_range(0, 19) < 14) ? $urandom_range(6, 15) : $urandom_range(0, 5);
      start_frame(words);
      if (words > 5) put_option_area(words);
      if ($urandom_range(0, 6) == 0) fill_to(frame.size() + $urandom_range(20, 50));
      else fill_to(frame.size() + $urandom_range(0, 3));
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, frame.size());
         while (frame.size() > cut) void'(frame.pop_back());
      end
   endfunction

   // receiver: random stalls, calm stretches and the long hold-off
   initial begin
      int stall;
      int calm;
      calm = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 17);
            if ($urandom_range(0, 4) == 0) calm = $urandom_range(3, 12);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one-byte headers
      frame = {8'hFF};
      send_frame();
      frame = {8'h00};
      send_frame();
      // no options, including an invalid offset
      start_frame(5);
      send_frame();
      start_frame(0);
      send_frame();
      // truncated before the base header ends
      start_frame(5);
      while (frame.size() > 15) void'(frame.pop_back());
      send_frame();
      // timestamp after no-ops, all ones
      start_frame(8);
      frame.push_back(KIND_NOP);
      frame.push_back(KIND_NOP);
      frame.push_back(KIND_TS);
      frame.push_back(TS_LEN);
      repeat (4) frame.push_back(8'hFF);
      fill_to(32);
      send_frame();
      // end of list
      start_frame(6);
      frame.push_back(KIND_EOL);
      fill_to(24);
      send_frame();
      // short length bytes
      start_frame(6);
      frame.push_back(8'd2);
      frame.push_back(8'd1);
      fill_to(24);
      send_frame();
      start_frame(7);
      frame.push_back(8'd3);
      frame.push_back(8'd0);
      fill_to(28);
      send_frame();
      // option kind in the last byte of the option area
      start_frame(6);
      frame.push_back(KIND_NOP);
      frame.push_back(KIND_NOP);
      frame.push_back(KIND_NOP);
      frame.push_back(8'd5);
      send_frame();
      // option length past the header
      start_frame(6);
      frame.push_back(8'd3);
      frame.push_back(8'd9);
      fill_to(24);
      send_frame();
      // header cut inside the timestamp value
      start_frame(8);
      frame.push_back(KIND_TS);
      frame.push_back(TS_LEN);
      frame.push_back(8'h12);
      frame.push_back(8'h34);
      send_frame();
      // kind 8 with a wrong length is skipped
      start_frame(7);
      frame.push_back(KIND_TS);
      frame.push_back(8'd8);
      fill_to(28);
      send_frame();
      // largest offset, zero timestamp at the end, stream past the counter limit
      start_frame(15);
      frame.push_back(8'd4);
      frame.push_back(MIN_LEN);
      frame.push_back(8'd30);
      frame.push_back(8'd28);
      fill_to(50);
      frame.push_back(KIND_TS);
      frame.push_back(TS_LEN);
      repeat (4) frame.push_back(8'h00);
      fill_to(75);
      send_frame();
      // largest offset filled with no-ops
      start_frame(15);
      while (frame.size() < 60) frame.push_back(KIND_NOP);
      send_frame();
      wait_drained();

      for (int round = 0; bytes_sent < 900; round++) begin
         if (round == 4) begin
            // receiver holds off while short headers keep coming
            hold_cycles  = 300;
            quiet_sender = 1'b1;
            repeat (8) begin
               frame.delete();
               fill_to($urandom_range(1, 3));
               send_frame();
            end
            wait_drained();
         end
         quiet_sender = ($urandom_range(0, 3) == 0);
         build_random_frame();
         send_frame();
      end
      quiet_sender = 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d header beats in %0d headers with gaps, stalls and a long hold-off",
               bytes_sent, frames_sent);
      $display("%0d results checked, %0d with a timestamp found", checked_count, found_count);
      if (bad_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for results");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tsx_pkg.sv
sv/tsx_walk.sv
sv/tcp_timestamp_option_extract_unit.sv
tb/ts_extract_check.sv
tb/tcp_timestamp_option_extract_unit_test.sv
